// ===== rtl/cuv_pkg.sv =====
// ----------------------------------------------------------------------------
// cuv_pkg
// Shared types, codes and the CRC-32 byte update for the chunked upload
// validator.
// ----------------------------------------------------------------------------
`default_nettype none

package cuv_pkg;

  // Item kinds. Codes five to seven carry no meaning and are ignored.
  localparam logic [2:0] KIND_BEGIN  = 3'd0;
  localparam logic [2:0] KIND_HEADER = 3'd1;
  localparam logic [2:0] KIND_DATA   = 3'd2;
  localparam logic [2:0] KIND_FINISH = 3'd3;
  localparam logic [2:0] KIND_ABORT  = 3'd4;

  // Result kinds.
  localparam logic RES_STATUS = 1'b0;
  localparam logic RES_WRITE  = 1'b1;

  // Status codes.
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_ACTIVE      = 4'd1;
  localparam logic [3:0] ST_SIZE        = 4'd2;
  localparam logic [3:0] ST_NOT_STARTED = 4'd3;
  localparam logic [3:0] ST_OFFSET      = 4'd4;
  localparam logic [3:0] ST_EMPTY       = 4'd5;
  localparam logic [3:0] ST_CHUNK_SIZE  = 4'd6;
  localparam logic [3:0] ST_OVERFLOW    = 4'd7;
  localparam logic [3:0] ST_INCOMPLETE  = 4'd8;
  localparam logic [3:0] ST_CRC         = 4'd9;

  // Configuration register indexes.
  localparam logic CFG_MAX_PACKAGE = 1'b0;
  localparam logic CFG_MAX_CHUNK   = 1'b1;

  // Configuration reset values.
  localparam logic [31:0] MAX_PACKAGE_RESET = 32'd65536;
  localparam logic [15:0] MAX_CHUNK_RESET   = 16'd512;

  // CRC-32, reflected form.
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // One input item.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] total_len;
    logic [31:0] expected_crc;
    logic [31:0] chunk_offset;
    logic [15:0] chunk_size;
    logic [7:0]  data_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        result_kind;
    logic [3:0]  status_code;
    logic [31:0] offset_hint;
    logic [31:0] offending_value;
    logic [31:0] limit_value;
    logic [31:0] write_address;
    logic [7:0]  write_byte;
  } result_t;

  // Advance the CRC by one byte, eight bit steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'd0);
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cuv_session.sv =====
// ----------------------------------------------------------------------------
// cuv_session
// Session state, chunk checks and CRC for one registered item per cycle while item_valid is high.
// ----------------------------------------------------------------------------
`default_nettype none

module cuv_session (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             item_valid,
  input  wire cuv_pkg::item_t   item,
  input  wire logic [31:0]      max_package_bytes,
  input  wire logic [15:0]      max_chunk_bytes,
  output logic                  res_valid,
  output cuv_pkg::result_t      res
);

  logic        active_r,   active_nxt;
  logic [31:0] size_r,     size_nxt;
  logic [31:0] crc_want_r, crc_want_nxt;
  logic [31:0] received_r, received_nxt;
  logic [15:0] owed_r,     owed_nxt;
  logic [31:0] crc_r,      crc_nxt;

  logic [31:0] room;
  logic [31:0] crc_final;

  assign room      = size_r - received_r;
  assign crc_final = ~crc_r;

  // Decide the result and the next session state for the current item.
  always_comb begin
    active_nxt   = active_r;
    size_nxt     = size_r;
    crc_want_nxt = crc_want_r;
    received_nxt = received_r;
    owed_nxt     = owed_r;
    crc_nxt      = crc_r;
    res_valid    = 1'b0;
    res          = '0;

    unique case (item.kind)
      cuv_pkg::KIND_BEGIN: begin
        res_valid = 1'b1;
        priority if (active_r) begin
          res.status_code     = cuv_pkg::ST_ACTIVE;
          res.offset_hint     = received_r;
          res.offending_value = received_r;
          res.limit_value     = size_r;
        end else if (item.total_len == 32'd0 ||
                     item.total_len > max_package_bytes) begin
          res.status_code     = cuv_pkg::ST_SIZE;
          res.offending_value = item.total_len;
          res.limit_value     = max_package_bytes;
        end else begin
          active_nxt   = 1'b1;
          size_nxt     = item.total_len;
          crc_want_nxt = item.expected_crc;
          received_nxt = '0;
          owed_nxt     = '0;
          crc_nxt      = cuv_pkg::CRC_INIT;
          res.status_code = cuv_pkg::ST_OK;
        end
      end

      cuv_pkg::KIND_HEADER: begin
        // A new header always drops what an earlier chunk still owes.
        owed_nxt  = '0;
        res_valid = 1'b1;
        priority if (!active_r) begin
          res.status_code = cuv_pkg::ST_NOT_STARTED;
        end else if (item.chunk_offset != received_r) begin
          res.status_code     = cuv_pkg::ST_OFFSET;
          res.offset_hint     = received_r;
          res.offending_value = item.chunk_offset;
          res.limit_value     = size_r;
        end else if (item.chunk_size == 16'd0) begin
          res.status_code = cuv_pkg::ST_EMPTY;
          res.offset_hint = received_r;
        end else if (item.chunk_size > max_chunk_bytes) begin
          res.status_code     = cuv_pkg::ST_CHUNK_SIZE;
          res.offset_hint     = received_r;
          res.offending_value = {16'd0, item.chunk_size};
          res.limit_value     = {16'd0, max_chunk_bytes};
        end else if ({16'd0, item.chunk_size} > room) begin
          res.status_code     = cuv_pkg::ST_OVERFLOW;
          res.offset_hint     = received_r;
          res.offending_value = received_r + {16'd0, item.chunk_size};
          res.limit_value     = size_r;
        end else begin
          owed_nxt        = item.chunk_size;
          res.status_code = cuv_pkg::ST_OK;
        end
      end

      cuv_pkg::KIND_DATA: begin
        // Stray bytes are dropped without a result.
        if (active_r && owed_r != 16'd0) begin
          res_valid         = 1'b1;
          res.result_kind   = cuv_pkg::RES_WRITE;
          res.write_address = received_r;
          res.write_byte    = item.data_byte;
          crc_nxt           = cuv_pkg::crc_byte(crc_r, item.data_byte);
          received_nxt      = received_r + 32'd1;
          owed_nxt          = owed_r - 16'd1;
        end
      end

      cuv_pkg::KIND_FINISH: begin
        res_valid = 1'b1;
        priority if (!active_r) begin
          res.status_code = cuv_pkg::ST_NOT_STARTED;
        end else if (received_r != size_r) begin
          res.status_code     = cuv_pkg::ST_INCOMPLETE;
          res.offset_hint     = received_r;
          res.offending_value = received_r;
          res.limit_value     = size_r;
        end else begin
          active_nxt   = 1'b0;
          size_nxt     = '0;
          crc_want_nxt = '0;
          received_nxt = '0;
          owed_nxt     = '0;
          crc_nxt      = cuv_pkg::CRC_INIT;
          if (crc_final != crc_want_r) begin
            res.status_code     = cuv_pkg::ST_CRC;
            res.offset_hint     = size_r;
            res.offending_value = crc_final;
            res.limit_value     = crc_want_r;
          end else begin
            res.status_code = cuv_pkg::ST_OK;
          end
        end
      end

      cuv_pkg::KIND_ABORT: begin
        active_nxt   = 1'b0;
        size_nxt     = '0;
        crc_want_nxt = '0;
        received_nxt = '0;
        owed_nxt     = '0;
        crc_nxt      = cuv_pkg::CRC_INIT;
      end

      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Session registers update once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      size_r     <= '0;
      crc_want_r <= '0;
      received_r <= '0;
      owed_r     <= '0;
      crc_r      <= cuv_pkg::CRC_INIT;
    end else if (item_valid) begin
      active_r   <= active_nxt;
      size_r     <= size_nxt;
      crc_want_r <= crc_want_nxt;
      received_r <= received_nxt;
      owed_r     <= owed_nxt;
      crc_r      <= crc_nxt;
    end
  end

  // An idle session holds no count and owes no bytes.
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (received_r == 32'd0 && owed_r == 16'd0 && size_r == 32'd0))
    else $error("idle session holds a count");

  // Accepted chunks never run past the announced size.
  a_within_size: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> ({1'b0, received_r} + {17'd0, owed_r} <= {1'b0, size_r}))
    else $error("received plus owed bytes exceed announced size");

  // A payload write always advances the count by one.
  a_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && res_valid && res.result_kind == cuv_pkg::RES_WRITE)
      |=> (received_r == $past(received_r) + 32'd1))
    else $error("payload write did not advance the byte count");

endmodule

`default_nettype wire

// ===== rtl/chunked_upload_validator_crc32_top.sv =====
// ----------------------------------------------------------------------------
// chunked_upload_validator_crc32_top
// Chunked upload receiver with session checks and a CRC-32 over the payload.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while in_stall is low and returns
// its result, if any, from an output register: the item is captured in an
// input register, checked against the session state and run through a
// one-byte CRC-32 update combinationally, and the result lands in the output
// register. Throughput is one item per cycle unless out_stall holds a result.
// While a result waits on out_stall, one further item may be taken into the
// input register; after that in_stall rises until the result is taken.
// Configuration writes are taken at any time but belong to idle periods.
`default_nettype none

module chunked_upload_validator_crc32_top (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic [31:0] in_total_len,
  input  wire logic [31:0] in_expected_crc,
  input  wire logic [31:0] in_chunk_offset,
  input  wire logic [15:0] in_chunk_size,
  input  wire logic [7:0]  in_data_byte,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_kind,
  output logic [3:0]       out_status_code,
  output logic [31:0]      out_offset_hint,
  output logic [31:0]      out_offending_value,
  output logic [31:0]      out_limit_value,
  output logic [31:0]      out_write_address,
  output logic [7:0]       out_write_byte
);

  logic [31:0]      max_package_r;
  logic [15:0]      max_chunk_r;
  logic             in_v_r;
  cuv_pkg::item_t   item_r;
  logic             out_v_r;
  cuv_pkg::result_t res_r;
  logic             res_valid;
  cuv_pkg::result_t res;
  logic             in_take;
  logic             advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_package_r <= cuv_pkg::MAX_PACKAGE_RESET;
      max_chunk_r   <= cuv_pkg::MAX_CHUNK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cuv_pkg::CFG_MAX_PACKAGE: max_package_r <= cfg_data;
        cuv_pkg::CFG_MAX_CHUNK:   max_chunk_r   <= cfg_data[15:0];
        default:                  max_package_r <= max_package_r;
      endcase
    end
  end

  // The held item moves on whenever the output register is free or emptying.
  assign advance  = in_v_r && !(out_v_r && out_stall);
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.kind         <= in_kind;
      item_r.total_len    <= in_total_len;
      item_r.expected_crc <= in_expected_crc;
      item_r.chunk_offset <= in_chunk_offset;
      item_r.chunk_size   <= in_chunk_size;
      item_r.data_byte    <= in_data_byte;
    end
  end

  cuv_session u_session (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (advance),
    .item              (item_r),
    .max_package_bytes (max_package_r),
    .max_chunk_bytes   (max_chunk_r),
    .res_valid         (res_valid),
    .res               (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= res_valid;
    end else if (out_v_r && !out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_v_r;
  assign out_result_kind     = res_r.result_kind;
  assign out_status_code     = res_r.status_code;
  assign out_offset_hint     = res_r.offset_hint;
  assign out_offending_value = res_r.offending_value;
  assign out_limit_value     = res_r.limit_value;
  assign out_write_address   = res_r.write_address;
  assign out_write_byte      = res_r.write_byte;

endmodule

`default_nettype wire
